>>> design/sensor_frame_crc_check_convert_defines.svh
// assertion macros shared by the sensor frame checker modules
`ifndef SENSOR_FRAME_CRC_CHECK_CONVERT_DEFINES_SVH
`define SENSOR_FRAME_CRC_CHECK_CONVERT_DEFINES_SVH

// same-cycle implication, clocked on clk, disabled while arst_n is low
`define SCFCC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scfcc assertion failed");

// next-cycle implication, clocked on clk, disabled while arst_n is low
`define SCFCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scfcc assertion failed");

`endif

>>> design/scfcc_pkg.sv
// types, constants and crc function of the sensor frame checker
package scfcc_pkg;

	localparam int FifoDepth = 4;
	localparam int FifoPtrW = $clog2(FifoDepth);
	localparam int FifoCntW = $clog2(FifoDepth + 1);

	localparam logic [23:0] PolyAligned = 24'h988000;
	localparam logic [15:0] StatusMask = 16'hFFFC;
	localparam logic [14:0] TempCoef = 15'd21965;
	localparam logic [14:0] HumCoef = 15'd15625;
	localparam logic [17:0] TempOffset = 18'd46850;
	localparam logic [17:0] HumOffset = 18'd6000;
	localparam int ConvShift = 13;
	localparam int ProdW = 31;

	localparam logic KindTemp = 1'b0;

	localparam logic [1:0] PosHigh = 2'd0;
	localparam logic [1:0] PosLow = 2'd1;
	localparam logic [1:0] PosCrc = 2'd2;
	localparam logic [1:0] PosUnused = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic frame_start;
		logic kind;
	} in_item_t;

	typedef struct packed {
		logic signed [17:0] value;
		logic crc_error;
		logic kind_out;
	} out_item_t;

	typedef struct packed {
		logic [15:0] raw;
		logic [7:0] crc;
		logic kind;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [7:0] crc_remainder(input logic [15:0] raw, input logic [7:0] crc);
		logic [23:0] rem;
		logic [23:0] div;
		rem = {raw, crc};
		div = PolyAligned;
		for (int i = 0; i < 16; i++) begin
			if (rem[23 - i]) begin
				rem = rem ^ div;
			end
			div = div >> 1;
		end
		return rem[7:0];
	endfunction

endpackage

>>> design/scfcc_front.sv
// front end: byte position tracking and frame assembly
`include "sensor_frame_crc_check_convert_defines.svh"

module scfcc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  scfcc_pkg::in_item_t   item,
	input  scfcc_pkg::fifo_stat_t stat,
	output logic                  wr_en,
	output scfcc_pkg::frame_t     frame
);

	logic [1:0] pos_q;
	logic [7:0] raw_high_q;
	logic [7:0] raw_low_q;
	logic kind_q;
	logic accept;
	logic take_high;

	assign accept = push && !stat.full;
	assign take_high = item.frame_start || (pos_q == scfcc_pkg::PosHigh)
		|| (pos_q == scfcc_pkg::PosUnused);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= scfcc_pkg::PosHigh;
			raw_high_q <= '0;
			raw_low_q <= '0;
			kind_q <= 1'b0;
		end else if (accept) begin
			if (take_high) begin
				raw_high_q <= item.data_byte;
				kind_q <= item.kind;
				pos_q <= scfcc_pkg::PosLow;
			end else if (pos_q == scfcc_pkg::PosLow) begin
				raw_low_q <= item.data_byte;
				pos_q <= scfcc_pkg::PosCrc;
			end else begin
				pos_q <= scfcc_pkg::PosHigh;
			end
		end
	end

	assign wr_en = accept && !take_high && (pos_q == scfcc_pkg::PosCrc);
	assign frame.raw = {raw_high_q, raw_low_q};
	assign frame.crc = item.data_byte;
	assign frame.kind = kind_q;

	`SCFCC_ASSERT_IMPL(a_pos_valid, 1'b1, pos_q != scfcc_pkg::PosUnused)

endmodule

>>> design/scfcc_fifo.sv
// short frame queue between front and back end
`include "sensor_frame_crc_check_convert_defines.svh"

module scfcc_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  scfcc_pkg::frame_t     wr_data,
	input  logic                  rd_en,
	output scfcc_pkg::frame_t     rd_data,
	output scfcc_pkg::fifo_stat_t stat
);

	localparam logic [scfcc_pkg::FifoPtrW-1:0] LastPtr =
		scfcc_pkg::FifoPtrW'(scfcc_pkg::FifoDepth - 1);
	localparam logic [scfcc_pkg::FifoCntW-1:0] FullCnt =
		scfcc_pkg::FifoCntW'(scfcc_pkg::FifoDepth);

	scfcc_pkg::frame_t mem_q [scfcc_pkg::FifoDepth];
	logic [scfcc_pkg::FifoPtrW-1:0] wr_ptr_q;
	logic [scfcc_pkg::FifoPtrW-1:0] rd_ptr_q;
	logic [scfcc_pkg::FifoCntW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign stat.full = (count_q == FullCnt);
	assign stat.empty = (count_q == '0);

	`SCFCC_ASSERT_IMPL(a_no_write_full, wr_en, !stat.full)
	`SCFCC_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= FullCnt)
	`SCFCC_ASSERT_NEXT(a_count_grow, wr_en && !rd_en, count_q == $past(count_q) + 1'b1)

endmodule

>>> design/scfcc_back.sv
// back end: crc check, scaling multiply and result register
`include "sensor_frame_crc_check_convert_defines.svh"

module scfcc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scfcc_pkg::frame_t     frame,
	input  scfcc_pkg::fifo_stat_t stat,
	output logic                  rd_en,
	input  logic                  pop,
	output logic                  empty,
	output scfcc_pkg::out_item_t  result
);

	logic valid_s1;
	logic [scfcc_pkg::ProdW-1:0] product_s1;
	logic good_s1;
	logic kind_s1;
	logic out_valid_q;
	scfcc_pkg::out_item_t out_q;

	logic ready_out;
	logic ready_s1;
	logic [15:0] ticks;
	logic [14:0] coef;
	logic [17:0] scaled;
	logic [17:0] offset;
	logic [18:0] diff;

	assign ready_out = !out_valid_q || pop;
	assign ready_s1 = !valid_s1 || ready_out;
	assign rd_en = !stat.empty && ready_s1;

	assign ticks = frame.raw & scfcc_pkg::StatusMask;
	assign coef = (frame.kind == scfcc_pkg::KindTemp) ? scfcc_pkg::TempCoef
		: scfcc_pkg::HumCoef;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			product_s1 <= scfcc_pkg::ProdW'(coef) * scfcc_pkg::ProdW'(ticks);
			good_s1 <= (scfcc_pkg::crc_remainder(frame.raw, frame.crc) == 8'd0);
			kind_s1 <= frame.kind;
		end
	end

	assign scaled = product_s1[scfcc_pkg::ConvShift +: 18];
	assign offset = (kind_s1 == scfcc_pkg::KindTemp) ? scfcc_pkg::TempOffset
		: scfcc_pkg::HumOffset;
	assign diff = {1'b0, scaled} - {1'b0, offset};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_out) begin
			out_q.value <= good_s1 ? signed'(diff[17:0]) : '0;
			out_q.crc_error <= !good_s1;
			out_q.kind_out <= kind_s1;
		end
	end

	assign empty = !out_valid_q;
	assign result = out_q;

	`SCFCC_ASSERT_NEXT(a_s1_hold, valid_s1 && !ready_s1, valid_s1 && $stable(product_s1))

endmodule

>>> design/sensor_frame_crc_check_convert.sv
// top level of the sensor frame crc checker and converter
// throughput: one byte per cycle while not full; a result follows every third frame byte
// a taken crc byte completes a frame, which is written into the queue; from there
// s1 registers the crc check and multiply, then the offset feeds the output register
// a four-entry frame queue lets the byte side run while results wait to be popped
// reset: arst_n clears byte position, queue and valid flags; no results are pending
module sensor_frame_crc_check_convert (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  scfcc_pkg::in_item_t  item,
	output logic                 empty,
	input  logic                 pop,
	output scfcc_pkg::out_item_t result
);

	scfcc_pkg::fifo_stat_t stat;
	scfcc_pkg::frame_t wr_frame;
	scfcc_pkg::frame_t rd_frame;
	logic wr_en;
	logic rd_en;

	scfcc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.stat   (stat),
		.wr_en  (wr_en),
		.frame  (wr_frame)
	);

	scfcc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_frame),
		.rd_en   (rd_en),
		.rd_data (rd_frame),
		.stat    (stat)
	);

	scfcc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (rd_frame),
		.stat   (stat),
		.rd_en  (rd_en),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	assign full = stat.full;

endmodule

>>> tb/tb_sensor_frame_crc_check_convert.sv
// testbench for the sensor frame crc checker and converter
`timescale 1ns / 1ps

module tb_sensor_frame_crc_check_convert;

	localparam int CycleLimit = 200000;
	localparam int RandomPerPhase = 485;
	localparam int SettleCycles = 8;
	localparam logic KindHum = 1'b1;
	localparam int unsigned TempScale = 21965;
	localparam int unsigned HumScale = 15625;
	localparam int TempBias = 46850;
	localparam int HumBias = 6000;
	localparam int ScaleShift = 13;
	localparam logic [15:0] TicksMask = 16'hFFFC;
	localparam logic [7:0] Crc8Poly = 8'h31;

	class frame_scoreboard;
		logic [1:0] byte_pos;
		logic [7:0] raw_hi;
		logic [7:0] raw_lo;
		logic frame_kind;
		scfcc_pkg::out_item_t readings_due[$];
		int errors;

		function new();
			byte_pos = scfcc_pkg::PosHigh;
			raw_hi = '0;
			raw_lo = '0;
			frame_kind = scfcc_pkg::KindTemp;
			errors = 0;
		endfunction

		static function logic [7:0] crc8(input logic [15:0] raw);
			logic [7:0] c;
			logic fb;
			c = '0;
			for (int i = 15; i >= 0; i--) begin
				fb = c[7] ^ raw[i];
				c = c << 1;
				if (fb) begin
					c = c ^ Crc8Poly;
				end
			end
			return c;
		endfunction

		function scfcc_pkg::out_item_t predict_reading(input logic [7:0] crc_byte);
			scfcc_pkg::out_item_t r;
			logic [15:0] raw;
			logic [15:0] ticks;
			int unsigned prod;
			int v;
			raw = {raw_hi, raw_lo};
			ticks = raw & TicksMask;
			r.kind_out = frame_kind;
			r.crc_error = (crc8(raw) != crc_byte);
			if (r.crc_error) begin
				v = 0;
			end else if (frame_kind == scfcc_pkg::KindTemp) begin
				prod = TempScale * ticks;
				v = int'(prod >> ScaleShift) - TempBias;
			end else begin
				prod = HumScale * ticks;
				v = int'(prod >> ScaleShift) - HumBias;
			end
			r.value = v[17:0];
			return r;
		endfunction

		function void note_byte(input scfcc_pkg::in_item_t it);
			if (it.frame_start || byte_pos == scfcc_pkg::PosHigh
				|| byte_pos == scfcc_pkg::PosUnused) begin
				raw_hi = it.data_byte;
				frame_kind = it.kind;
				byte_pos = scfcc_pkg::PosLow;
			end else if (byte_pos == scfcc_pkg::PosLow) begin
				raw_lo = it.data_byte;
				byte_pos = scfcc_pkg::PosCrc;
			end else begin
				readings_due.push_back(predict_reading(it.data_byte));
				byte_pos = scfcc_pkg::PosHigh;
			end
		endfunction

		function void check_reading(input scfcc_pkg::out_item_t got);
			scfcc_pkg::out_item_t want;
			if (readings_due.size() == 0) begin
				$display("%0t unexpected result: expected none, got value %0d crc_error %0b kind %0b",
					$time, got.value, got.crc_error, got.kind_out);
				errors++;
				return;
			end
			want = readings_due.pop_front();
			if (got.value !== want.value) begin
				$display("%0t value mismatch: expected %0d, got %0d", $time, want.value, got.value);
				errors++;
			end
			if (got.crc_error !== want.crc_error) begin
				$display("%0t crc_error mismatch: expected %0b, got %0b",
					$time, want.crc_error, got.crc_error);
				errors++;
			end
			if (got.kind_out !== want.kind_out) begin
				$display("%0t kind_out mismatch: expected %0b, got %0b",
					$time, want.kind_out, got.kind_out);
				errors++;
			end
		endfunction

		function int pending();
			return readings_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	scfcc_pkg::in_item_t item = '0;
	logic full;
	logic empty;
	scfcc_pkg::out_item_t result;

	frame_scoreboard sb;
	bit hold_steady = 1'b0;
	int bytes_sent = 0;
	int cycles = 0;

	sensor_frame_crc_check_convert dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: check each popped transaction, stall at random unless hold_steady is set
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				sb.check_reading(result);
			end
			pop <= hold_steady || ($urandom_range(99) >= 31);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic start, input logic k);
		scfcc_pkg::in_item_t it;
		int gap;
		it.data_byte = b;
		it.frame_start = start;
		it.kind = k;
		gap = 0;
		if (!hold_steady) begin
			while ($urandom_range(99) < 31) begin
				gap++;
			end
		end
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		sb.note_byte(it);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [15:0] raw, input logic k, input logic [7:0] crc_flip);
		send_byte(raw[15:8], 1'b1, k);
		send_byte(raw[7:0], 1'b0, 1'($urandom_range(1)));
		send_byte(frame_scoreboard::crc8(raw) ^ crc_flip, 1'b0, 1'($urandom_range(1)));
	endtask

	task automatic drain_readings();
		push <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic random_traffic(input int count);
		int target;
		int pick;
		logic [15:0] raw;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if ($urandom_range(15) == 0) begin
				raw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			end else begin
				raw = 16'($urandom);
			end
			if (pick < 78) begin
				send_frame(raw, 1'($urandom_range(1)), 8'h00);
			end else if (pick < 90) begin
				send_frame(raw, 1'($urandom_range(1)), 8'($urandom_range(255, 1)));
			end else begin
				repeat ($urandom_range(4, 1)) begin
					send_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
				end
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(16'h0000, scfcc_pkg::KindTemp, 8'h00);
		send_frame(16'hFFFF, KindHum, 8'h00);
		send_frame(16'hFFFF, scfcc_pkg::KindTemp, 8'h00);
		send_frame(16'h683A, KindHum, 8'h01);
		// partial frame dropped by a new frame start
		send_byte(8'h5A, 1'b1, KindHum);
		send_byte(8'hA5, 1'b0, KindHum);
		send_frame(16'h1234, scfcc_pkg::KindTemp, 8'h00);
		// no frame start, kind changes on later bytes
		send_byte(8'hAB, 1'b0, KindHum);
		send_byte(8'hCD, 1'b0, scfcc_pkg::KindTemp);
		send_byte(frame_scoreboard::crc8(16'hABCD), 1'b0, scfcc_pkg::KindTemp);
		// status bits only
		send_frame(16'h0003, scfcc_pkg::KindTemp, 8'h00);
		drain_readings();

		for (int phase = 0; phase < 3; phase++) begin
			hold_steady = (phase == 1);
			random_traffic(RandomPerPhase);
			drain_readings();
		end
		hold_steady = 1'b0;

		repeat (SettleCycles) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> sensor_frame_crc_check_convert.f
+incdir+design
design/scfcc_pkg.sv
design/scfcc_front.sv
design/scfcc_fifo.sv
design/scfcc_back.sv
design/sensor_frame_crc_check_convert.sv
tb/tb_sensor_frame_crc_check_convert.sv
